### design/multi_slot_event_timer_defines.svh
// Assertion macros for the multi-slot event timer.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MULTI_SLOT_EVENT_TIMER_DEFINES_SVH
`define MULTI_SLOT_EVENT_TIMER_DEFINES_SVH

// Clocked property, switched off while reset is held.
`define MSET_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define MSET_NEVER(name, expr, msg) \
  `MSET_ASSERT(name, !(expr), msg)

`endif

### design/mset_pkg.sv
// Shared constants, codes and controller/datapath bundles of the event timer.
// No dependencies.
package mset_pkg;

  localparam int SLOTS   = 16;
  localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index
  localparam int CW      = $clog2(SLOTS + 1);                // slot counts
  localparam int MAX_OUT = 16;                               // fired results per tick
  localparam int EW      = $clog2(MAX_OUT + 1);
  localparam int TIME_W  = 32;
  localparam int DIV_W   = 20;
  localparam int ID_W    = 16;
  localparam int TAG_W   = 16;
  localparam int ACT_W   = 3;
  localparam int ST_W    = 3;
  localparam int SLOT_W  = 4;
  localparam int ACNT_W  = 5;
  localparam int ACNT_MAX = (1 << ACNT_W) - 1;
  localparam logic [DIV_W-1:0] STEP_RST = DIV_W'(1000);

  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_CYC = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADD_ONE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_ID  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_TAG = 3'd4;

  localparam logic [ST_W-1:0] ST_FIRED    = 3'd0;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd1;
  localparam logic [ST_W-1:0] ST_ADDED    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_DELETED  = 3'd4;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;
  localparam logic [ST_W-1:0] ST_REJECT   = 3'd6;

  // Controller to datapath.
  typedef struct packed {
    logic            load;        // capture request fields
    logic            cnt_clr;     // clear tick bookkeeping
    logic            pre_step;    // tick pass one: count fires and one-shot drops
    logic            apply_drop;  // settle occupancy for this tick
    logic            tick_step;   // tick pass two: update slot, report fire
    logic            div_start;
    logic            add_write;
    logic            del_clear;
    logic            emit;        // final result of the request
    logic [ST_W-1:0] status;
    logic            emit_slot;   // report idx as slot, else 0
    logic [IW-1:0]   idx;
  } mset_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic occ;
    logic match;
    logic div_done;
    logic no_fire;
  } mset_stat_t;

  function automatic logic [ACNT_W-1:0] act_sat(input logic [CW-1:0] a);
    logic [ACNT_W-1:0] r;
    if (int'(a) > ACNT_MAX) r = ACNT_W'(ACNT_MAX);
    else r = ACNT_W'(a);
    return r;
  endfunction

endpackage

### design/multi_slot_event_timer.sv
// Multi-slot event timer: top level joining controller and datapath.
// Depends on mset_pkg, mset_ctrl, mset_dp and multi_slot_event_timer_defines.svh.
//
//   channel   | handshake                | payload
//   ----------+--------------------------+---------------------------------------------
//   request   | start / busy             | action_i time_us_i event_id_i tag_i
//   config    | step_us_we_i             | step_us_i
//   result    | result_valid_o (strobe)  | status_o slot_o fired_id_o fired_tag_o
//             |                          | active_count_o last_o
//
// A request is taken when start is high and busy is low; each result is on the ports for
// one cycle under its strobe, in the cycle after it is formed. A tick walks the table twice,
// one slot per cycle. An add keeps the block busy while the 32-step divider runs, or answers
// ST_FULL once the search finds no free slot; a delete searches the table slot by slot;
// rejects and other requests answer without going busy. Reset empties all slots and loads
// step_us with 1000. The result side cannot stall; the last result may overlap the next request.
`include "multi_slot_event_timer_defines.svh"

module multi_slot_event_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        step_us_we_i,
  input  logic [mset_pkg::DIV_W-1:0]  step_us_i,
  input  logic [mset_pkg::ACT_W-1:0]  action_i,
  input  logic [mset_pkg::TIME_W-1:0] time_us_i,
  input  logic [mset_pkg::ID_W-1:0]   event_id_i,
  input  logic [mset_pkg::TAG_W-1:0]  tag_i,
  output logic                        result_valid_o,
  output logic [mset_pkg::ST_W-1:0]   status_o,
  output logic [mset_pkg::SLOT_W-1:0] slot_o,
  output logic [mset_pkg::ID_W-1:0]   fired_id_o,
  output logic [mset_pkg::TAG_W-1:0]  fired_tag_o,
  output logic [mset_pkg::ACNT_W-1:0] active_count_o,
  output logic                        last_o
);
  import mset_pkg::*;

  mset_cmd_t  cmd;
  mset_stat_t stat;

  mset_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .action_i  (action_i),
    .event_id_i(event_id_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  mset_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .step_us_we_i  (step_us_we_i),
    .step_us_i     (step_us_i),
    .action_i      (action_i),
    .time_us_i     (time_us_i),
    .event_id_i    (event_id_i),
    .tag_i         (tag_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .fired_id_o    (fired_id_o),
    .fired_tag_o   (fired_tag_o),
    .active_count_o(active_count_o),
    .last_o        (last_o)
  );

  // a burst of fire reports must not let the next request in
  `MSET_ASSERT(a_busy_in_burst, result_valid_o && !last_o |-> busy, "request taken mid-burst")
  // every accepted request either answers at once or keeps the block busy
  `MSET_ASSERT(a_req_answered, start && !busy |=> busy || result_valid_o, "request dropped")
  `MSET_NEVER(a_fire_empty, result_valid_o && status_o == ST_FIRED && fired_id_o == '0, "empty slot fired")
  `MSET_ASSERT(a_count_range, result_valid_o |-> int'(active_count_o) <= SLOTS, "occupancy overrun")

endmodule

### design/mset_div.sv
// Restoring divider, one quotient bit per cycle: time in us by step in us.
// Depends on mset_pkg.
module mset_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mset_pkg::TIME_W-1:0] dividend_i,
  input  logic [mset_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [mset_pkg::TIME_W-1:0] quotient_o
);
  import mset_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic             run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [TIME_W-1:0] quo_q, quo_d;
  logic [DIV_W:0]   sh, diff;
  logic             ge;

  assign sh   = {rem_q, quo_q[TIME_W-1]};
  assign diff = sh - {1'b0, dvs_q};
  assign ge   = sh >= {1'b0, dvs_q};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      quo_d = {quo_q[TIME_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(TIME_W - 1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = !run_q;
  assign quotient_o = quo_q;

endmodule

### design/mset_dp.sv
// Datapath: slot table, tick bookkeeping, step register, divider, result register.
// Depends on mset_pkg and mset_div.
module mset_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mset_pkg::mset_cmd_t         cmd_i,
  output mset_pkg::mset_stat_t        stat_o,
  input  logic                        step_us_we_i,
  input  logic [mset_pkg::DIV_W-1:0]  step_us_i,
  input  logic [mset_pkg::ACT_W-1:0]  action_i,
  input  logic [mset_pkg::TIME_W-1:0] time_us_i,
  input  logic [mset_pkg::ID_W-1:0]   event_id_i,
  input  logic [mset_pkg::TAG_W-1:0]  tag_i,
  output logic                        result_valid_o,
  output logic [mset_pkg::ST_W-1:0]   status_o,
  output logic [mset_pkg::SLOT_W-1:0] slot_o,
  output logic [mset_pkg::ID_W-1:0]   fired_id_o,
  output logic [mset_pkg::TAG_W-1:0]  fired_tag_o,
  output logic [mset_pkg::ACNT_W-1:0] active_count_o,
  output logic                        last_o
);
  import mset_pkg::*;

  // Slot table
  logic [ID_W-1:0]   id_q  [SLOTS];
  logic [TAG_W-1:0]  tag_q [SLOTS];
  logic [TIME_W-1:0] per_q [SLOTS];
  logic [TIME_W-1:0] cnt_q [SLOTS];
  logic              once_q[SLOTS];

  // Captured request
  logic [ACT_W-1:0]  act_l_q;
  logic [ID_W-1:0]   id_l_q;
  logic [TAG_W-1:0]  tag_l_q;

  logic [DIV_W-1:0]  step_q;
  logic [CW-1:0]     active_q, active_d, drop_q, drop_d;
  logic [EW-1:0]     fire_tot_q, fire_tot_d, emit_cnt_q, emit_cnt_d;

  logic [ID_W-1:0]   rid;
  logic [TAG_W-1:0]  rtag;
  logic [TIME_W-1:0] rper, rcnt, cnt_inc, quo, per_new;
  logic              ronce, occ, fire, match, fire_emit, div_done;
  logic [DIV_W-1:0]  divisor;

  logic              val_d;
  logic [ST_W-1:0]   st_d;
  logic [SLOT_W-1:0] slot_d;
  logic [ID_W-1:0]   fid_d;
  logic [TAG_W-1:0]  ftag_d;
  logic              last_d;

  assign rid     = id_q[cmd_i.idx];
  assign rtag    = tag_q[cmd_i.idx];
  assign rper    = per_q[cmd_i.idx];
  assign rcnt    = cnt_q[cmd_i.idx];
  assign ronce   = once_q[cmd_i.idx];
  assign occ     = rid != '0;
  // a live count stays below its period, so the increment cannot wrap
  assign cnt_inc = rcnt + TIME_W'(1);
  assign fire    = occ && (cnt_inc >= rper);
  assign match   = (rid == id_l_q) && ((act_l_q == ACT_DEL_ID) || (rtag == tag_l_q));
  assign per_new = (quo == '0) ? TIME_W'(1) : quo;
  assign divisor = (step_q == '0) ? DIV_W'(1) : step_q;

  mset_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(time_us_i),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  assign stat_o.occ      = occ;
  assign stat_o.match    = match;
  assign stat_o.div_done = div_done;
  assign stat_o.no_fire  = fire_tot_q == '0;

  assign fire_emit = cmd_i.tick_step && fire && (emit_cnt_q != EW'(MAX_OUT));

  always_comb begin
    drop_d     = drop_q;
    fire_tot_d = fire_tot_q;
    emit_cnt_d = emit_cnt_q;
    active_d   = active_q;
    if (cmd_i.cnt_clr) begin
      drop_d     = '0;
      fire_tot_d = '0;
      emit_cnt_d = '0;
    end
    if (cmd_i.pre_step && fire) begin
      if (ronce) drop_d = drop_q + CW'(1);
      if (fire_tot_q != EW'(MAX_OUT)) fire_tot_d = fire_tot_q + EW'(1);
    end
    if (fire_emit) emit_cnt_d = emit_cnt_q + EW'(1);
    if (cmd_i.apply_drop) active_d = active_q - drop_q;
    else if (cmd_i.add_write) active_d = active_q + CW'(1);
    else if (cmd_i.del_clear) active_d = active_q - CW'(1);
  end

  // Result register
  always_comb begin
    val_d  = fire_emit || cmd_i.emit;
    st_d   = cmd_i.status;
    slot_d = cmd_i.emit_slot ? SLOT_W'(cmd_i.idx) : '0;
    fid_d  = '0;
    ftag_d = '0;
    last_d = 1'b1;
    if (fire_emit) begin
      st_d   = ST_FIRED;
      slot_d = SLOT_W'(cmd_i.idx);
      fid_d  = rid;
      ftag_d = rtag;
      last_d = (emit_cnt_q + EW'(1)) == fire_tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= STEP_RST;
      active_q       <= '0;
      drop_q         <= '0;
      fire_tot_q     <= '0;
      emit_cnt_q     <= '0;
      result_valid_o <= 1'b0;
    end else begin
      if (step_us_we_i) step_q <= step_us_i;
      active_q       <= active_d;
      drop_q         <= drop_d;
      fire_tot_q     <= fire_tot_d;
      emit_cnt_q     <= emit_cnt_d;
      result_valid_o <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_o       <= st_d;
    slot_o         <= slot_d;
    fired_id_o     <= fid_d;
    fired_tag_o    <= ftag_d;
    active_count_o <= act_sat(active_d);
    last_o         <= last_d;
  end

  // Request capture; the divider takes time_us directly at the accepting edge
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_l_q  <= action_i;
      id_l_q   <= event_id_i;
      tag_l_q  <= tag_i;
    end
  end

  // Ids mark occupancy, so they clear on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) id_q[i] <= '0;
    end else if (cmd_i.add_write) begin
      id_q[cmd_i.idx] <= id_l_q;
    end else if (cmd_i.del_clear) begin
      id_q[cmd_i.idx] <= '0;
    end else if (cmd_i.tick_step && fire && ronce) begin
      id_q[cmd_i.idx] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      tag_q[cmd_i.idx]  <= tag_l_q;
      per_q[cmd_i.idx]  <= per_new;
      cnt_q[cmd_i.idx]  <= '0;
      once_q[cmd_i.idx] <= act_l_q == ACT_ADD_ONE;
    end else if (cmd_i.tick_step && occ) begin
      cnt_q[cmd_i.idx]  <= fire ? '0 : cnt_inc;
    end
  end

endmodule

### design/mset_ctrl.sv
// Controller: sequences ticks, adds and deletes over the slot table.
// Depends on mset_pkg.
module mset_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mset_pkg::ACT_W-1:0] action_i,
  input  logic [mset_pkg::ID_W-1:0]  event_id_i,
  input  mset_pkg::mset_stat_t       stat_i,
  output mset_pkg::mset_cmd_t        cmd_o,
  output logic                       busy_o
);
  import mset_pkg::*;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_TICK_A     = 3'd1;
  localparam logic [2:0] S_TICK_APPLY = 3'd2;
  localparam logic [2:0] S_TICK_B     = 3'd3;
  localparam logic [2:0] S_TICK_END   = 3'd4;
  localparam logic [2:0] S_ADD_SRCH   = 3'd5;
  localparam logic [2:0] S_ADD_WAIT   = 3'd6;
  localparam logic [2:0] S_DEL_SRCH   = 3'd7;

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          last_idx, id_zero;

  assign last_idx = idx_q == LAST_IDX;
  assign id_zero  = event_id_i == '0;

  always_comb begin
    cmd_o     = '0;
    cmd_o.idx = idx_q;
    state_d   = state_q;
    idx_d     = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          if (action_i == ACT_TICK) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_TICK_A;
          end else if (action_i == ACT_ADD_CYC || action_i == ACT_ADD_ONE) begin
            if (id_zero) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_REJECT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_ADD_SRCH;
            end
          end else if (action_i == ACT_DEL_ID || action_i == ACT_DEL_TAG) begin
            if (id_zero) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_REJECT;
            end else begin
              state_d = S_DEL_SRCH;
            end
          end else begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NONE;
          end
        end
      end
      // first pass only counts, so every report can carry the final occupancy
      S_TICK_A: begin
        cmd_o.pre_step = 1'b1;
        idx_d          = idx_q + IW'(1);
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_TICK_APPLY;
        end
      end
      S_TICK_APPLY: begin
        cmd_o.apply_drop = 1'b1;
        state_d          = S_TICK_B;
      end
      S_TICK_B: begin
        cmd_o.tick_step = 1'b1;
        idx_d           = idx_q + IW'(1);
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_TICK_END;
        end
      end
      S_TICK_END: begin
        if (stat_i.no_fire) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_NONE;
        end
        state_d = S_IDLE;
      end
      S_ADD_SRCH: begin
        if (!stat_i.occ) begin
          state_d = S_ADD_WAIT;
        end else if (last_idx) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_FULL;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_ADD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.add_write = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.status    = ST_ADDED;
          cmd_o.emit_slot = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DEL_SRCH: begin
        if (stat_i.match) begin
          cmd_o.del_clear = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.status    = ST_DELETED;
          cmd_o.emit_slot = 1'b1;
          state_d         = S_IDLE;
        end else if (last_idx) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_NOTFOUND;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

### bench/mset_checker.sv
// Checker for the multi-slot event timer: watches requests, step_us writes and results,
// keeps its own copy of the slot table and compares every result in arrival order.
// Depends on mset_pkg.
`timescale 1ns / 100ps

module mset_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        step_us_we_i,
  input  logic [mset_pkg::DIV_W-1:0]  step_us_i,
  input  logic [mset_pkg::ACT_W-1:0]  action_i,
  input  logic [mset_pkg::TIME_W-1:0] time_us_i,
  input  logic [mset_pkg::ID_W-1:0]   event_id_i,
  input  logic [mset_pkg::TAG_W-1:0]  tag_i,
  input  logic                        result_valid_i,
  input  logic [mset_pkg::ST_W-1:0]   status_i,
  input  logic [mset_pkg::SLOT_W-1:0] slot_i,
  input  logic [mset_pkg::ID_W-1:0]   fired_id_i,
  input  logic [mset_pkg::TAG_W-1:0]  fired_tag_i,
  input  logic [mset_pkg::ACNT_W-1:0] active_count_i,
  input  logic                        last_i,
  output int                          mismatches_o,
  output int                          reports_due_o,
  output int                          reports_seen_o
);
  import mset_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
    logic [ACNT_W-1:0] active;
    logic              last;
  } timer_report_t;

  // Shadow slot table.
  logic [ID_W-1:0]   ident_m  [SLOTS];
  logic [TAG_W-1:0]  utag_m   [SLOTS];
  logic [TIME_W-1:0] period_m [SLOTS];
  logic [TIME_W-1:0] count_m  [SLOTS];
  logic              once_m   [SLOTS];
  logic [DIV_W-1:0]  step_m;

  timer_report_t reports_due[$];
  int errors;
  int seen;

  function automatic void clear_slot(input int i);
    ident_m[i]  = '0;
    utag_m[i]   = '0;
    period_m[i] = '0;
    count_m[i]  = '0;
    once_m[i]   = 1'b0;
  endfunction

  // Applies one request to the shadow table and queues the reports it should produce.
  task automatic run_timer_table(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] t,
                                 input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag);
    timer_report_t batch[$];
    timer_report_t r;
    logic [TIME_W-1:0] div;
    int occ;
    bit done;
    r = '0;
    done = 1'b0;
    occ = 0;
    case (act)
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (ident_m[i] != '0) begin
            count_m[i] = count_m[i] + 1'b1;
            if (count_m[i] >= period_m[i]) begin
              r = '0;
              r.status = ST_FIRED;
              r.slot = SLOT_W'(i);
              r.id = ident_m[i];
              r.tag = utag_m[i];
              if (once_m[i]) clear_slot(i);
              count_m[i] = '0;
              // firings past the report limit still take effect
              if (batch.size() < MAX_OUT) batch.push_back(r);
            end
          end
        end
        if (batch.size() == 0) begin
          r = '0;
          r.status = ST_NONE;
          batch.push_back(r);
        end
      end
      ACT_ADD_CYC, ACT_ADD_ONE: begin
        if (id == '0) begin
          r.status = ST_REJECT;
        end else begin
          div = (step_m == '0) ? TIME_W'(1) : TIME_W'(step_m);
          r.status = ST_FULL;
          for (int i = 0; i < SLOTS && !done; i++) begin
            if (ident_m[i] == '0) begin
              ident_m[i] = id;
              utag_m[i] = tag;
              count_m[i] = '0;
              once_m[i] = (act == ACT_ADD_ONE);
              period_m[i] = t / div;
              if (period_m[i] == '0) period_m[i] = TIME_W'(1);
              r.status = ST_ADDED;
              r.slot = SLOT_W'(i);
              done = 1'b1;
            end
          end
        end
        batch.push_back(r);
      end
      ACT_DEL_ID, ACT_DEL_TAG: begin
        if (id == '0) begin
          r.status = ST_REJECT;
        end else begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < SLOTS && !done; i++) begin
            if (ident_m[i] == id && (act == ACT_DEL_ID || utag_m[i] == tag)) begin
              clear_slot(i);
              r.status = ST_DELETED;
              r.slot = SLOT_W'(i);
              done = 1'b1;
            end
          end
        end
        batch.push_back(r);
      end
      default: begin
        r.status = ST_NONE;
        batch.push_back(r);
      end
    endcase
    for (int i = 0; i < SLOTS; i++) if (ident_m[i] != '0) occ++;
    if (occ > ACNT_MAX) occ = ACNT_MAX;
    foreach (batch[k]) begin
      batch[k].active = ACNT_W'(occ);
      batch[k].last = (k == batch.size() - 1);
      reports_due.push_back(batch[k]);
    end
  endtask

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_report();
    timer_report_t want;
    seen++;
    if (reports_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, expected none actual status %0d slot %0d",
               $time, status_i, slot_i);
    end else begin
      want = reports_due.pop_front();
      compare_field("status", want.status, status_i);
      compare_field("slot", want.slot, slot_i);
      compare_field("fired_id", want.id, fired_id_i);
      compare_field("fired_tag", want.tag, fired_tag_i);
      compare_field("active_count", want.active, active_count_i);
      compare_field("last", want.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_m = STEP_RST;
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
      reports_due.delete();
      errors = 0;
      seen = 0;
    end else begin
      // a result may leave in the same cycle the next request is taken
      if (result_valid_i) check_report();
      if (step_us_we_i) step_m = step_us_i;
      if (start_i && !busy_i) run_timer_table(action_i, time_us_i, event_id_i, tag_i);
    end
    mismatches_o <= errors;
    reports_due_o <= reports_due.size();
    reports_seen_o <= seen;
  end

endmodule

### bench/tb.sv
// Top of the event timer bench: clock, reset, request and step_us stimulus, verdict.
// Depends on mset_pkg, multi_slot_event_timer and mset_checker.
`timescale 1ns / 100ps

module tb;
  import mset_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 92;
  localparam int LIVE_KEEP    = 32;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
  } event_key_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              step_us_we_i = 1'b0;
  logic [DIV_W-1:0]  step_us_i = '0;
  logic [ACT_W-1:0]  action_i = ACT_TICK;
  logic [TIME_W-1:0] time_us_i = '0;
  logic [ID_W-1:0]   event_id_i = '0;
  logic [TAG_W-1:0]  tag_i = '0;
  logic              result_valid_o;
  logic [ST_W-1:0]   status_o;
  logic [SLOT_W-1:0] slot_o;
  logic [ID_W-1:0]   fired_id_o;
  logic [TAG_W-1:0]  fired_tag_o;
  logic [ACNT_W-1:0] active_count_o;
  logic              last_o;

  int mismatches;
  int reports_due;
  int reports_seen;
  int requests_sent = 0;
  int step_writes = 0;
  int idle_cycles = 0;
  int no_gap_left = 0;
  logic [DIV_W-1:0] cur_step = STEP_RST;
  event_key_t live_events[$];

  multi_slot_event_timer i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .step_us_we_i,
    .step_us_i,
    .action_i,
    .time_us_i,
    .event_id_i,
    .tag_i,
    .result_valid_o,
    .status_o,
    .slot_o,
    .fired_id_o,
    .fired_tag_o,
    .active_count_o,
    .last_o
  );

  mset_checker i_checker (
    .clk_i,
    .rst_ni,
    .start_i(start),
    .busy_i(busy),
    .step_us_we_i,
    .step_us_i,
    .action_i,
    .time_us_i,
    .event_id_i,
    .tag_i,
    .result_valid_i(result_valid_o),
    .status_i(status_o),
    .slot_i(slot_o),
    .fired_id_i(fired_id_o),
    .fired_tag_i(fired_tag_o),
    .active_count_i(active_count_o),
    .last_i(last_o),
    .mismatches_o(mismatches),
    .reports_due_o(reports_due),
    .reports_seen_o(reports_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: %0d cycles without a request or result", IDLE_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  // time_us that lands on the given tick period under the current step, with a random remainder
  function automatic logic [TIME_W-1:0] time_for(input int ticks);
    longint unsigned div;
    div = (cur_step == '0) ? 1 : cur_step;
    return TIME_W'(div * ticks + $urandom_range(0, 32'(div - 1)));
  endfunction

  // Called at the edge that took the previous request; start stays high for back-to-back.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] t,
                              input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag);
    int gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 15) == 0) no_gap_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    time_us_i <= t;
    event_id_i <= id;
    tag_i <= tag;
    do @(posedge clk_i); while (busy);
    requests_sent++;
    if ((act == ACT_ADD_CYC || act == ACT_ADD_ONE) && id != '0) begin
      live_events.push_back('{id, tag});
      if (live_events.size() > LIVE_KEEP) void'(live_events.pop_front());
    end
  endtask

  // Holds off requests until every expected result is back and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (reports_due != 0 || busy);
  endtask

  task automatic write_step(input logic [DIV_W-1:0] v);
    settle();
    step_us_we_i <= 1'b1;
    step_us_i <= v;
    @(posedge clk_i);
    step_us_we_i <= 1'b0;
    cur_step = v;
    step_writes++;
  endtask

  // Add SLOTS+1 period-1 cyclic events so the table fills and overflows, fire, then thin out.
  task automatic fill_and_fire();
    event_key_t k;
    for (int n = 0; n <= SLOTS; n++) begin
      send_request(ACT_ADD_CYC, time_for($urandom_range(0, 1)),
                   ID_W'($urandom_range(1, 65535)), TAG_W'($urandom));
    end
    repeat (2) send_request(ACT_TICK, '0, '0, '0);
    repeat (SLOTS / 2) begin
      if (live_events.size() > 0) begin
        k = live_events.pop_back();
        send_request(ACT_DEL_ID, '0, k.id, k.tag);
      end
    end
  endtask

  task automatic random_item();
    int pick;
    int idx;
    logic [ACT_W-1:0] act;
    event_key_t k;
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      send_request(ACT_TICK, TIME_W'($urandom), ID_W'($urandom), TAG_W'($urandom));
    end else if (pick < 62) begin
      // small id pool gives duplicates; wide ids toggle the upper bits
      k.id = ($urandom_range(0, 9) < 3) ? ID_W'($urandom_range(1, 65535))
                                         : ID_W'($urandom_range(1, 20));
      k.tag = TAG_W'($urandom);
      act = ($urandom_range(0, 1) != 0) ? ACT_ADD_ONE : ACT_ADD_CYC;
      send_request(act, ($urandom_range(0, 6) == 0) ? TIME_W'($urandom)
                                                    : time_for($urandom_range(0, 6)),
                   k.id, k.tag);
    end else if (pick < 90) begin
      act = (pick < 78) ? ACT_DEL_ID : ACT_DEL_TAG;
      if (live_events.size() > 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, live_events.size() - 1);
        k = live_events[idx];
        if (act == ACT_DEL_TAG && $urandom_range(0, 3) == 0) k.tag ^= TAG_W'($urandom_range(1, 65535));
        else live_events.delete(idx);
      end else begin
        k.id = ID_W'($urandom_range(1, 65535));
        k.tag = TAG_W'($urandom);
      end
      send_request(act, TIME_W'($urandom), k.id, k.tag);
    end else if (pick < 95) begin
      send_request(ACT_W'($urandom_range(ACT_DEL_TAG + 1, (1 << ACT_W) - 1)), TIME_W'($urandom),
                   ID_W'($urandom), TAG_W'($urandom));
    end else begin
      send_request(ACT_W'($urandom_range(ACT_ADD_CYC, ACT_DEL_TAG)), TIME_W'($urandom), '0,
                   TAG_W'($urandom));
    end
  endtask

  initial begin
    logic [DIV_W-1:0] step_val;
    int phase_end;
    int fill_at;
    bit filled;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, step_us at its reset value
    send_request(ACT_TICK, '0, '0, '0);
    send_request(ACT_ADD_CYC, TIME_W'(5), '0, TAG_W'(3));
    send_request(ACT_DEL_ID, '0, '0, '0);
    send_request(ACT_DEL_TAG, '0, '0, '1);
    send_request(ACT_DEL_ID, '0, ID_W'(5), '0);
    send_request(ACT_ADD_CYC, '0, ID_W'(1), '0);
    send_request(ACT_ADD_ONE, TIME_W'(3 * STEP_RST), '1, '1);
    send_request(ACT_ADD_CYC, '1, ID_W'(2), TAG_W'(16'h1234));
    repeat (3) send_request(ACT_TICK, '0, '0, '0);
    send_request(ACT_ADD_CYC, TIME_W'(2 * STEP_RST), ID_W'(2), TAG_W'(7));
    send_request(ACT_DEL_TAG, '0, ID_W'(2), TAG_W'(9));
    // tag match skips the lower slot holding the same id
    send_request(ACT_DEL_TAG, '0, ID_W'(2), TAG_W'(16'h1234));
    send_request(ACT_DEL_ID, '0, ID_W'(2), '0);
    for (int a = ACT_DEL_TAG + 1; a < (1 << ACT_W); a++) send_request(ACT_W'(a), '1, '1, '1);
    send_request(ACT_ADD_ONE, TIME_W'(STEP_RST - 1), ID_W'(3), TAG_W'(16'h8001));
    send_request(ACT_TICK, '0, '0, '0);
    send_request(ACT_DEL_ID, '0, ID_W'(1), '0);
    send_request(ACT_TICK, '0, '0, '0);
    // table is empty here: every slot fires on the same tick
    fill_and_fire();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: step_val = DIV_W'(1);
        1: step_val = '1;
        2: step_val = '0;
        3: step_val = DIV_W'($urandom_range(2, (1 << DIV_W) - 2));
        default: step_val = STEP_RST;
      endcase
      write_step(step_val);
      phase_end = requests_sent + PHASE_ITEMS;
      fill_at = requests_sent + $urandom_range(5, 50);
      filled = 1'b0;
      while (requests_sent < phase_end) begin
        if (!filled && requests_sent >= fill_at) begin
          fill_and_fire();
          filled = 1'b1;
        end else begin
          random_item();
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests over %0d step_us settings incl. 0, 1 and max,",
             requests_sent, step_writes + 1);
    $display("with table overflow and full-table firing; %0d results compared.", reports_seen);
    if (reports_due != 0) $display("%0d expected results never arrived", reports_due);
    if (mismatches == 0 && reports_due == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
